FILE: sv/bldi_pkg.sv
`timescale 1ns / 1ps

package bldi_pkg;

  localparam int DATA_W       = 32;
  localparam int MODE_W       = 2;
  localparam int DEF_CAPACITY = 64;

  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INS_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LIST      = 2'd3;

  // output tuser bits
  localparam int USER_EMPTY   = 0;
  localparam int USER_DROPPED = 1;

endpackage

FILE: sv/bldi_ram.sv
`timescale 1ns / 1ps

module bldi_ram #(
  parameter int DEPTH = bldi_pkg::DEF_CAPACITY,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bldi_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [bldi_pkg::DATA_W-1:0] rdata
);

  logic [bldi_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/bounded_list_head_tail_delete_index.sv
`timescale 1ns / 1ps
// each request passes through the command state, an optional delete state that shifts
//   entries toward the front, then the listing state (one empty result for an empty list)
// requests: s_tready is high only while idle, so a new request is taken only once the last
//   result of the previous listing is loaded; one read port carries shift and listing
// reset: count, head pointer and handshakes clear; store contents stay undefined, no sweep
module bounded_list_head_tail_delete_index #(
  parameter int CAPACITY = bldi_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // value [31:0], position [63:32]
  input  logic [1:0]  s_tuser,   // mode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // element [31:0]
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // empty_res [0], dropped [1]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [AW-1:0] TOP_A = AW'(CAPACITY - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMD  = 2'd1;
  localparam logic [1:0] ST_DEL  = 2'd2;
  localparam logic [1:0] ST_LIST = 2'd3;

  function automatic logic [AW-1:0] phys(logic [AW-1:0] base, logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, idx};
    if (sum >= (CW + 1)'(CAPACITY)) begin
      sum = sum - (CW + 1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  logic [1:0]                  state;
  logic [CW-1:0]               count;
  logic [AW-1:0]               head;
  logic [bldi_pkg::MODE_W-1:0] req_mode;
  logic [31:0]                 req_value;
  logic [31:0]                 req_pos;
  logic                        drop_q;
  logic [CW-1:0]               sidx;
  logic [CW-1:0]               li;
  logic                        pending;
  logic                        pend_last;
  logic                        wr_pend;
  logic [AW-1:0]               wr_addr;

  logic                        is_ins;
  logic                        ins_ok;
  logic                        del_ok;
  logic [AW-1:0]               head_dec;
  logic                        del_issue;
  logic                        out_free;
  logic                        load;
  logic                        empty_load;
  logic                        list_issue;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [31:0]                 wdata;
  logic                        re;
  logic [AW-1:0]               raddr;
  logic [31:0]                 rdata;

  assign s_tready = (state == ST_IDLE);

  assign is_ins   = (req_mode == bldi_pkg::MODE_INS_FRONT) ||
                    (req_mode == bldi_pkg::MODE_INS_BACK);
  assign ins_ok   = is_ins && (count != CAP_C);
  assign del_ok   = (req_mode == bldi_pkg::MODE_DELETE) && !req_pos[31] &&
                    (req_pos < {{(32 - CW){1'b0}}, count});
  assign head_dec = (head == '0) ? TOP_A : head - 1'b1;

  assign del_issue  = (state == ST_DEL) && (sidx != count);
  assign out_free   = !m_tvalid || m_tready;
  assign load       = pending && out_free;
  assign empty_load = (state == ST_LIST) && (count == '0) && out_free;
  assign list_issue = (state == ST_LIST) && (li != count) && (!pending || load);

  assign we    = ((state == ST_CMD) && ins_ok) || wr_pend;
  assign waddr = (state == ST_CMD) ?
                 ((req_mode == bldi_pkg::MODE_INS_FRONT) ? head_dec : phys(head, count)) :
                 wr_addr;
  assign wdata = (state == ST_CMD) ? req_value : rdata;
  assign re    = del_issue || list_issue;
  assign raddr = phys(head, (state == ST_DEL) ? sidx : li);

  bldi_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      head    <= '0;
      pending <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= del_issue;
      if (list_issue) begin
        pending <= 1'b1;
      end else if (load) begin
        pending <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CMD;
          end
        end
        ST_CMD: begin
          if (ins_ok) begin
            count <= count + 1'b1;
            if (req_mode == bldi_pkg::MODE_INS_FRONT) begin
              head <= head_dec;
            end
          end
          state <= del_ok ? ST_DEL : ST_LIST;
        end
        ST_DEL: begin
          if (sidx == count) begin
            count <= count - 1'b1;
            state <= ST_LIST;
          end
        end
        ST_LIST: begin
          if (count == '0) begin
            if (empty_load) begin
              state <= ST_IDLE;
            end
          end else if ((li == count) && !pending) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request capture and sweep indexes
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_mode  <= s_tuser;
      req_value <= s_tdata[31:0];
      req_pos   <= s_tdata[63:32];
    end
    if (state == ST_CMD) begin
      drop_q <= is_ins && !ins_ok;
      sidx   <= req_pos[CW-1:0] + 1'b1;
      li     <= '0;
    end
    if (del_issue) begin
      sidx    <= sidx + 1'b1;
      wr_addr <= phys(head, sidx - 1'b1);
    end
    if (list_issue) begin
      li        <= li + 1'b1;
      pend_last <= (li == count - 1'b1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load || empty_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata                        <= rdata;
      m_tlast                        <= pend_last;
      m_tuser[bldi_pkg::USER_EMPTY]   <= 1'b0;
      m_tuser[bldi_pkg::USER_DROPPED] <= drop_q;
    end else if (empty_load) begin
      m_tdata                        <= '0;
      m_tlast                        <= 1'b1;
      m_tuser[bldi_pkg::USER_EMPTY]   <= 1'b1;
      m_tuser[bldi_pkg::USER_DROPPED] <= drop_q;
    end
  end

endmodule

FILE: sv/bldi_checker.sv
`timescale 1ns / 1ps

module bldi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // an empty listing is one zero result
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[bldi_pkg::USER_EMPTY] |-> m_tlast && (m_tdata == 32'd0))
    else $error("empty result malformed");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken back to back");

  // no new request while a listing is still open
  a_list_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("request taken mid listing");

endmodule

bind bounded_list_head_tail_delete_index bldi_checker u_bldi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
